// ===== rtl/fpc_pkg.sv =====
package fpc_pkg;

    // Default number of cache slots.
    localparam int unsigned SLOT_COUNT_DEF = 1024;

    // FNV-1a 64-bit hash constants. The prime is 2^40 + 0x1b3.
    localparam logic [63:0] FNV_OFFSET = 64'hcbf2_9ce4_8422_2325;

    // The key is hashed as 38 bytes, first byte in the top bits.
    localparam int unsigned KEY_BYTES = 38;
    localparam int unsigned KEY_W     = KEY_BYTES * 8;
    localparam int unsigned HASH_W    = 64;
    localparam int unsigned META_W    = 44;

    // Fragment kind codes. The fourth code is handled like an unfragmented packet.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_FIRST = 2'd1;
    localparam logic [1:0] KIND_LATER = 2'd2;

    typedef struct packed {
        logic [META_W-1:0] meta;     // version, protocol, fragment id
        logic [63:0]       src_hi;
        logic [63:0]       src_lo;
        logic [63:0]       dst_hi;
        logic [63:0]       dst_lo;
        logic [31:0]       ports;    // source port high, destination port low
    } slot_entry_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } store_cmd_t;

    // One FNV-1a round: xor in a byte, then multiply by the prime as shifted adds.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ===== rtl/fragment_flow_port_cache.sv =====
// Fragment port cache: a direct-mapped cache that lends layer 4 ports to later
// IP fragments. Each transfer on the s_ channel is one decoded packet header and
// yields exactly one transfer on the m_ channel. A first fragment that carries
// layer 4 stores its key (version, protocol, fragment id, both addresses) and its
// ports in the slot chosen by the 64-bit FNV-1a hash of the key modulo
// SLOT_COUNT. A later fragment whose key fully matches its slot gets the stored
// ports and m_attributed set; every other packet passes its own ports through.
// Items are processed one at a time. The hash unit mixes one key byte per cycle
// over the whole key, then, when SLOT_COUNT is not a power of two, reduces the
// hash to a remainder (four 16-bit digits, a multiply and a subtract each).
// After the hash, a later fragment reads its slot, compares it, loads the
// output register and returns to idle before the next transfer can be
// accepted; a first fragment writes its slot and skips the compare. A packet
// that needs no lookup goes from idle straight to the output load. A finished
// result waits in the output register while the next transfer is accepted; a
// result that cannot be loaded because the previous one is still waiting holds
// the block until m_ready frees the register. After reset a clearing pass over
// every slot resets the valid bits; s_ready stays low until it ends.
module fragment_flow_port_cache import fpc_pkg::*; #(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_packet_usable,
    input  logic [1:0]  s_frag_kind,
    input  logic        s_has_transport,
    input  logic [3:0]  s_ip_version,
    input  logic [7:0]  s_ip_protocol,
    input  logic [31:0] s_fragment_id,
    input  logic [63:0] s_src_addr_hi,
    input  logic [63:0] s_src_addr_lo,
    input  logic [63:0] s_dst_addr_hi,
    input  logic [63:0] s_dst_addr_lo,
    input  logic [15:0] s_src_port_in,
    input  logic [15:0] s_dst_port_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_attributed,
    output logic [15:0] m_src_port_out,
    output logic [15:0] m_dst_port_out
);

    localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_CMP,
        S_OUT
    } ctrl_state_t;

    ctrl_state_t state_reg;
    slot_entry_t entry_reg;       // key and ports of the item in progress
    logic        first_reg;       // item is a first fragment that will be stored
    logic        res_hit_reg;
    logic [15:0] res_sp_reg;
    logic [15:0] res_dp_reg;
    logic        m_valid_reg;
    logic        m_attributed_reg;
    logic [15:0] m_sport_reg;
    logic [15:0] m_dport_reg;

    logic              accept;
    logic              lookup;
    logic              hash_start;
    logic              hash_done;
    logic [SLOT_W-1:0] hash_index;
    logic [KEY_W-1:0]  hash_key;
    store_cmd_t        store_cmd;
    logic              store_ready;
    logic              slot_valid;
    slot_entry_t       slot_data;
    logic              key_match;

    // An item is accepted only between items and once the valid bits are clear.
    assign s_ready = (state_reg == S_IDLE) && store_ready;
    assign accept  = s_valid && s_ready;

    // Only usable first fragments with layer 4, and usable later fragments,
    // touch the cache. Everything else passes straight to the result.
    assign lookup = s_packet_usable &&
                    (((s_frag_kind == KIND_FIRST) && s_has_transport) ||
                     (s_frag_kind == KIND_LATER));
    assign hash_start = accept && lookup;

    // The version is hashed as one zero-extended byte, the id big-endian.
    assign hash_key = {4'd0, s_ip_version, s_ip_protocol, s_fragment_id,
                       s_src_addr_hi, s_src_addr_lo, s_dst_addr_hi, s_dst_addr_lo};

    fpc_hash #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (hash_key),
        .done    (hash_done),
        .index   (hash_index)
    );

    // When the slot index is known, a first fragment writes its slot and a later
    // fragment reads it. Only one item is in flight, so a read never overlaps a
    // write to the same slot.
    assign store_cmd.wr = (state_reg == S_HASH) && hash_done && first_reg;
    assign store_cmd.rd = (state_reg == S_HASH) && hash_done && !first_reg;

    fpc_slot_store #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (store_cmd),
        .addr     (hash_index),
        .wr_data  (entry_reg),
        .ready    (store_ready),
        .rd_valid (slot_valid),
        .rd_data  (slot_data)
    );

    // A hit needs a valid slot and the whole key to agree; the ports are not key.
    assign key_match = slot_valid &&
                       (slot_data.meta   == entry_reg.meta)   &&
                       (slot_data.src_hi == entry_reg.src_hi) &&
                       (slot_data.src_lo == entry_reg.src_lo) &&
                       (slot_data.dst_hi == entry_reg.dst_hi) &&
                       (slot_data.dst_lo == entry_reg.dst_lo);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // The output register empties on a completed transfer, except in
            // the result state, where the load below decides its next value.
            if (m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        entry_reg.meta   <= {s_ip_version, s_ip_protocol, s_fragment_id};
                        entry_reg.src_hi <= s_src_addr_hi;
                        entry_reg.src_lo <= s_src_addr_lo;
                        entry_reg.dst_hi <= s_dst_addr_hi;
                        entry_reg.dst_lo <= s_dst_addr_lo;
                        entry_reg.ports  <= {s_src_port_in, s_dst_port_in};
                        first_reg        <= (s_frag_kind == KIND_FIRST);
                        res_hit_reg      <= 1'b0;
                        res_sp_reg       <= s_src_port_in;
                        res_dp_reg       <= s_dst_port_in;
                        state_reg        <= lookup ? S_HASH : S_OUT;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        state_reg <= first_reg ? S_OUT : S_CMP;
                    end
                end
                S_CMP: begin
                    // The slot read issued in the previous cycle is available now.
                    if (key_match) begin
                        res_hit_reg <= 1'b1;
                        res_sp_reg  <= slot_data.ports[31:16];
                        res_dp_reg  <= slot_data.ports[15:0];
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_attributed_reg <= res_hit_reg;
                        m_sport_reg      <= res_sp_reg;
                        m_dport_reg      <= res_dp_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_attributed   = m_attributed_reg;
    assign m_src_port_out = m_sport_reg;
    assign m_dst_port_out = m_dport_reg;

    // The hash unit only finishes while the controller waits for it.
    a_hash_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        hash_done |-> (state_reg == S_HASH))
        else $error("hash result arrived outside the hash wait state");

    // A slot read is always followed by the compare of its data.
    a_read_then_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        store_cmd.rd |=> (state_reg == S_CMP))
        else $error("slot read not followed by compare");

    // The compare uses data only from a read issued in the previous cycle.
    a_compare_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> $past(store_cmd.rd))
        else $error("compare without a preceding slot read");

    // No item is in progress while the valid bits are being cleared.
    a_idle_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !store_ready |-> (state_reg == S_IDLE))
        else $error("item in progress during the clearing pass");

endmodule

// ===== rtl/fpc_hash.sv =====
module fpc_hash import fpc_pkg::*; #(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [KEY_W-1:0]              key,
    output logic                          done,
    output logic [$clog2(SLOT_COUNT)-1:0] index
);

    localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
    localparam bit          IS_POW2    = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;
    localparam int unsigned DIGIT_W    = 16;
    localparam int unsigned MOD_DIGITS = HASH_W / DIGIT_W;
    localparam int unsigned MOD_SHIFT  = 32 + SLOT_W;
    // Rounded-up reciprocal of the slot count; exact quotients for 32-bit numerators.
    localparam logic [32:0] MOD_RECIP  =
        33'(((64'd1 << MOD_SHIFT) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT));

    typedef enum logic [1:0] {
        H_IDLE,
        H_MIX,
        H_MUL,
        H_SUB
    } hash_state_t;

    hash_state_t         state_reg;
    logic [HASH_W-1:0]   h_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [5:0]          cnt_reg;
    logic [SLOT_W-1:0]   rem_reg;
    logic [SLOT_W-1:0]   index_reg;
    logic                done_reg;
    logic [64:0]         mod_prod_reg;

    logic [HASH_W-1:0]   h_next;
    logic [31:0]         mod_num;
    logic [15:0]         mod_quot;
    logic [SLOT_W-1:0]   rem_next;

    assign h_next   = fnv_step(h_reg, key_reg[KEY_W-1 -: 8]);
    assign mod_num  = 32'({rem_reg, h_reg[HASH_W-1 -: DIGIT_W]});
    assign mod_quot = 16'(mod_prod_reg >> MOD_SHIFT);
    assign rem_next = SLOT_W'(mod_num - 32'(mod_quot) * 32'(SLOT_COUNT));

    // Bytes are mixed one per cycle. For a slot count that is not a power of
    // two the hash is then reduced 16 bits at a time: a reciprocal multiply
    // gives the digit quotient, and the next cycle subtracts quotient times
    // the slot count, for each of the four digits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                H_IDLE: begin
                    if (start) begin
                        h_reg     <= FNV_OFFSET;
                        key_reg   <= key;
                        cnt_reg   <= '0;
                        state_reg <= H_MIX;
                    end
                end
                H_MIX: begin
                    h_reg   <= h_next;
                    key_reg <= key_reg << 8;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(KEY_BYTES - 1)) begin
                        cnt_reg <= '0;
                        rem_reg <= '0;
                        if (IS_POW2) begin
                            index_reg <= h_next[SLOT_W-1:0];
                            done_reg  <= 1'b1;
                            state_reg <= H_IDLE;
                        end else begin
                            state_reg <= H_MUL;
                        end
                    end
                end
                H_MUL: begin
                    mod_prod_reg <= 65'(mod_num) * 65'(MOD_RECIP);
                    state_reg    <= H_SUB;
                end
                H_SUB: begin
                    rem_reg <= rem_next;
                    h_reg   <= h_reg << DIGIT_W;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(MOD_DIGITS - 1)) begin
                        index_reg <= rem_next;
                        done_reg  <= 1'b1;
                        state_reg <= H_IDLE;
                    end else begin
                        state_reg <= H_MUL;
                    end
                end
                default: state_reg <= H_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign index = index_reg;

endmodule

// ===== rtl/fpc_slot_store.sv =====
module fpc_slot_store import fpc_pkg::*; #(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  store_cmd_t                    cmd,
    input  logic [$clog2(SLOT_COUNT)-1:0] addr,
    input  slot_entry_t                   wr_data,
    output logic                          ready,
    output logic                          rd_valid,
    output slot_entry_t                   rd_data
);

    localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);

    logic        valid_mem [SLOT_COUNT];
    slot_entry_t data_mem  [SLOT_COUNT];

    logic [SLOT_W-1:0] clr_idx_reg;
    logic              clr_done_reg;
    logic              rd_valid_reg;
    slot_entry_t       rd_data_reg;

    // After reset the valid bits are cleared one slot per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg  <= '0;
            clr_done_reg <= 1'b0;
        end else if (!clr_done_reg) begin
            clr_idx_reg <= clr_idx_reg + SLOT_W'(1);
            if (clr_idx_reg == SLOT_W'(SLOT_COUNT - 1)) begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!clr_done_reg) begin
            valid_mem[clr_idx_reg] <= 1'b0;
        end else if (cmd.wr) begin
            valid_mem[addr] <= 1'b1;
        end
        if (cmd.rd) begin
            rd_valid_reg <= valid_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            data_mem[addr] <= wr_data;
        end
        if (cmd.rd) begin
            rd_data_reg <= data_mem[addr];
        end
    end

    assign ready    = clr_done_reg;
    assign rd_valid = rd_valid_reg;
    assign rd_data  = rd_data_reg;

endmodule
